// ===== design/atc_pkg.sv =====
`timescale 1ns / 1ps
package atc_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 28;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 3;
    localparam logic signed [63:0] CORDIC_GAIN_Q30 = 64'sd652032874;

    localparam logic [CFG_IDX_W-1:0] REG_POSITION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAST     = 3'd5;

    typedef logic signed [31:0] q_t;

    typedef struct packed {
        q_t a;
        q_t b;
        q_t c;
        q_t d;
        q_t tx;
        q_t ty;
    } mat_t;

    // Sequencer states of the local matrix builder.
    typedef enum logic [2:0] {S_IDLE, S_CORDIC, S_TRIG, S_LIN, S_TRANS} bstate_t;

    function automatic logic signed [63:0] atan_turn(input int i);
        logic signed [63:0] t;
        unique case (i)
            0: t = 64'sd536870912;   1: t = 64'sd316933406;
            2: t = 64'sd167458907;   3: t = 64'sd85004756;
            4: t = 64'sd42667329;    5: t = 64'sd21354465;
            6: t = 64'sd10679839;    7: t = 64'sd5340245;
            8: t = 64'sd2670163;     9: t = 64'sd1335087;
            10: t = 64'sd667544;     11: t = 64'sd333772;
            12: t = 64'sd166886;     13: t = 64'sd83443;
            14: t = 64'sd41722;      15: t = 64'sd20861;
            16: t = 64'sd10430;      17: t = 64'sd5215;
            18: t = 64'sd2608;       19: t = 64'sd1304;
            20: t = 64'sd652;        21: t = 64'sd326;
            22: t = 64'sd163;        23: t = 64'sd81;
            24: t = 64'sd41;         25: t = 64'sd20;
            26: t = 64'sd10;         27: t = 64'sd5;
            default: t = 64'sd0;
        endcase
        return t;
    endfunction

    function automatic q_t sat32(input logic signed [65:0] v);
        q_t r;
        if (v > 66'sd2147483647) r = 32'sh7fffffff;
        else if (v < -66'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    // Rounded half-up product of two Q values, exact in 64 bits.
    function automatic logic signed [63:0] mulr(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
        logic signed [65:0] p;
        p = a * b + (66'sd1 <<< (FRAC_BITS - 1));
        return 64'(p >>> FRAC_BITS);
    endfunction

endpackage

// ===== design/affine_2d_transform_compose.sv =====
`timescale 1ns / 1ps
// Accepted starts pass the operand, product and sum registers before done carries the word.
// Throughput: one word per cycle while the cached local matrix is clean or fast mode is on.
// After a config write outside fast mode busy is high; the first start then rebuilds the
// local matrix, the CORDIC iterating one step per cycle, and then words stream again.
// The receiver cannot stall: each world word is on the outputs for one cycle only.
// Reset (rst_n low, asynchronous) restores the register defaults and marks the cache dirty.
module affine_2d_transform_compose
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [63:0]           cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [31:0]    parent_a,
    input  logic signed [31:0]    parent_b,
    input  logic signed [31:0]    parent_c,
    input  logic signed [31:0]    parent_d,
    input  logic signed [31:0]    parent_tx,
    input  logic signed [31:0]    parent_ty,
    output logic                  done,
    output logic signed [31:0]    world_a,
    output logic signed [31:0]    world_b,
    output logic signed [31:0]    world_c,
    output logic signed [31:0]    world_d,
    output logic signed [31:0]    world_tx,
    output logic signed [31:0]    world_ty
);
    import atc_pkg::*;

    logic [63:0] position_reg, pivot_reg, scale_reg, size_reg;
    logic [15:0] angle_reg;
    logic        fast_reg;
    logic        dirty_reg;
    logic        building_reg;
    logic        build_done;
    logic        accept;
    mat_t        local_m, parent, world;

    // A start that finds the cache dirty is held off (busy) until the rebuild
    // finishes; the caller then presents it again. Fast mode needs no rebuild,
    // since only the position registers feed the translation path.
    assign busy   = building_reg || (dirty_reg && !fast_reg);
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            pivot_reg    <= '0;
            scale_reg    <= {32'(1 << FRAC_BITS), 32'(1 << FRAC_BITS)};
            size_reg     <= '0;
            angle_reg    <= '0;
            fast_reg     <= 1'b0;
            dirty_reg    <= 1'b1;
            building_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_POSITION: position_reg <= cfg_data;
                    REG_PIVOT:    pivot_reg    <= cfg_data;
                    REG_SCALE:    scale_reg    <= cfg_data;
                    REG_SIZE:     size_reg     <= cfg_data;
                    REG_ANGLE:    angle_reg    <= cfg_data[15:0];
                    REG_FAST:     fast_reg     <= cfg_data[0];
                    default: ;
                endcase
                if (cfg_index <= REG_FAST) dirty_reg <= 1'b1;
            end
            else if (building_reg && build_done)
            begin
                building_reg <= 1'b0;
                dirty_reg    <= 1'b0;
            end
            else if (dirty_reg && !fast_reg && !building_reg && start)
            begin
                building_reg <= 1'b1;
            end
        end
    end

    atc_local u_local
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .build          (dirty_reg && !fast_reg && !building_reg && start && !cfg_we),
        .position_xy    (position_reg),
        .pivot_xy       (pivot_reg),
        .scale_xy       (scale_reg),
        .size_xy        (size_reg),
        .rotation_angle (angle_reg),
        .done           (build_done),
        .local_m        (local_m)
    );

    assign parent = '{a: parent_a, b: parent_b, c: parent_c, d: parent_d,
                      tx: parent_tx, ty: parent_ty};

    atc_compose u_compose
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .parent    (parent),
        .local_m   (local_m),
        .fast      (fast_reg),
        .posx      (position_reg[31:0]),
        .posy      (position_reg[63:32]),
        .out_valid (done),
        .world     (world)
    );

    assign world_a  = world.a;
    assign world_b  = world.b;
    assign world_c  = world.c;
    assign world_d  = world.d;
    assign world_tx = world.tx;
    assign world_ty = world.ty;

endmodule

// ===== design/atc_local.sv =====
`timescale 1ns / 1ps
module atc_local
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              build,
    input  logic [63:0]       position_xy,
    input  logic [63:0]       pivot_xy,
    input  logic [63:0]       scale_xy,
    input  logic [63:0]       size_xy,
    input  logic [15:0]       rotation_angle,
    output logic              done,
    output atc_pkg::mat_t     local_m
);
    import atc_pkg::*;

    // Sequencer: CORDIC iterates one step per cycle, then the matrix terms.
    bstate_t state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic signed [63:0] x_reg, y_reg, z_reg;
    logic [1:0] q_reg;
    q_t cs_reg, sn_reg, px_reg, py_reg;
    mat_t m_reg;

    q_t posx, posy, pvx, pvy, szx, szy, sx, sy;
    logic [31:0] th, r;
    logic [1:0] q;
    logic signed [63:0] xr, yr, xc, yc, cc, ss;

    assign posx = position_xy[31:0];
    assign posy = position_xy[63:32];
    assign pvx  = pivot_xy[31:0];
    assign pvy  = pivot_xy[63:32];
    assign szx  = size_xy[31:0];
    assign szy  = size_xy[63:32];
    assign sx   = scale_xy[31:0];
    assign sy   = scale_xy[63:32];

    assign th = {rotation_angle[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
    assign q  = 2'((th + 32'h20000000) >> 30);
    assign r  = th - {q, 30'd0};

    always_comb
    begin
        xr = (x_reg + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        yr = (y_reg + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        xc = xr > (64'sd1 <<< FRAC_BITS) ? (64'sd1 <<< FRAC_BITS) :
             xr < -(64'sd1 <<< FRAC_BITS) ? -(64'sd1 <<< FRAC_BITS) : xr;
        yc = yr > (64'sd1 <<< FRAC_BITS) ? (64'sd1 <<< FRAC_BITS) :
             yr < -(64'sd1 <<< FRAC_BITS) ? -(64'sd1 <<< FRAC_BITS) : yr;
        unique case (q_reg)
            2'd0: begin cc = xc;  ss = yc;  end
            2'd1: begin cc = -yc; ss = xc;  end
            2'd2: begin cc = -xc; ss = -yc; end
            default: begin cc = yc; ss = -xc; end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:   if (build) begin state_next = S_CORDIC; step_next = '0; end
            S_CORDIC:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(CORDIC_STEPS - 1)) state_next = S_TRIG;
            end
            S_TRIG:   state_next = S_LIN;
            S_LIN:    state_next = S_TRANS;
            S_TRANS:  state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    assign done = (state_reg == S_TRANS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                x_reg  <= CORDIC_GAIN_Q30;
                y_reg  <= '0;
                z_reg  <= 64'(signed'(r));
                q_reg  <= q;
                px_reg <= (szx != 0) ? sat32(66'(mulr(33'(szx), 33'(pvx)))) : pvx;
                py_reg <= (szy != 0) ? sat32(66'(mulr(33'(szy), 33'(pvy)))) : pvy;
            end
            S_CORDIC:
            begin
                if (z_reg >= 0)
                begin
                    x_reg <= x_reg - (y_reg >>> step_reg);
                    y_reg <= y_reg + (x_reg >>> step_reg);
                    z_reg <= z_reg - atan_turn(int'(step_reg));
                end
                else
                begin
                    x_reg <= x_reg + (y_reg >>> step_reg);
                    y_reg <= y_reg - (x_reg >>> step_reg);
                    z_reg <= z_reg + atan_turn(int'(step_reg));
                end
            end
            S_TRIG:
            begin
                cs_reg <= cc[31:0];
                sn_reg <= ss[31:0];
            end
            S_LIN:
            begin
                m_reg.a <= sat32(66'(mulr(33'(cs_reg), 33'(sx))));
                m_reg.b <= sat32(66'(mulr(33'(sn_reg), 33'(sx))));
                m_reg.c <= sat32(66'(mulr(-33'(sn_reg), 33'(sy))));
                m_reg.d <= sat32(66'(mulr(33'(cs_reg), 33'(sy))));
            end
            S_TRANS:
            begin
                m_reg.tx <= sat32(66'(mulr(33'(px_reg), 33'(sx))) + 66'(posx)
                    - 66'(mulr(33'(m_reg.a), 33'(px_reg)))
                    - 66'(mulr(33'(m_reg.c), 33'(py_reg))));
                m_reg.ty <= sat32(66'(mulr(33'(py_reg), 33'(sy))) + 66'(posy)
                    - 66'(mulr(33'(m_reg.b), 33'(px_reg)))
                    - 66'(mulr(33'(m_reg.d), 33'(py_reg))));
            end
            default: ;
        endcase
    end

    assign local_m = m_reg;

endmodule

// ===== design/atc_compose.sv =====
`timescale 1ns / 1ps
module atc_compose
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  atc_pkg::mat_t   parent,
    input  atc_pkg::mat_t   local_m,
    input  logic            fast,
    input  atc_pkg::q_t     posx,
    input  atc_pkg::q_t     posy,
    output logic            out_valid,
    output atc_pkg::mat_t   world
);
    import atc_pkg::*;

    // Stage 1 registers the operands, stage 2 the twelve products, stage 3 the sums.
    logic v1_reg, v2_reg, v3_reg;
    logic f1_reg, f2_reg;
    mat_t p1_reg, l1_reg;
    mat_t l1_next;
    logic signed [63:0] pr_reg [12];
    q_t ptx2_reg, pty2_reg;
    mat_t w_reg;

    // In fast mode the translation comes straight from the position register.
    always_comb
    begin
        l1_next = local_m;
        if (fast)
        begin
            l1_next.tx = posx;
            l1_next.ty = posy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg <= parent;
        l1_reg <= l1_next;
        f1_reg <= fast;
        f2_reg   <= f1_reg;
        ptx2_reg <= p1_reg.tx;
        pty2_reg <= p1_reg.ty;
        pr_reg[0]  <= mulr(33'(p1_reg.a), 33'(l1_reg.a));
        pr_reg[1]  <= mulr(33'(p1_reg.c), 33'(l1_reg.b));
        pr_reg[2]  <= mulr(33'(p1_reg.b), 33'(l1_reg.a));
        pr_reg[3]  <= mulr(33'(p1_reg.d), 33'(l1_reg.b));
        pr_reg[4]  <= mulr(33'(p1_reg.a), 33'(l1_reg.c));
        pr_reg[5]  <= mulr(33'(p1_reg.c), 33'(l1_reg.d));
        pr_reg[6]  <= mulr(33'(p1_reg.b), 33'(l1_reg.c));
        pr_reg[7]  <= mulr(33'(p1_reg.d), 33'(l1_reg.d));
        pr_reg[8]  <= f1_reg ? 64'(l1_reg.tx) : mulr(33'(p1_reg.a), 33'(l1_reg.tx));
        pr_reg[9]  <= f1_reg ? 64'sd0 : mulr(33'(p1_reg.c), 33'(l1_reg.ty));
        pr_reg[10] <= f1_reg ? 64'(l1_reg.ty) : mulr(33'(p1_reg.b), 33'(l1_reg.tx));
        pr_reg[11] <= f1_reg ? 64'sd0 : mulr(33'(p1_reg.d), 33'(l1_reg.ty));
        if (f2_reg)
        begin
            w_reg.a <= q_t'(32'sd1 <<< FRAC_BITS);
            w_reg.b <= '0;
            w_reg.c <= '0;
            w_reg.d <= q_t'(32'sd1 <<< FRAC_BITS);
        end
        else
        begin
            w_reg.a <= sat32(66'(pr_reg[0]) + 66'(pr_reg[1]));
            w_reg.b <= sat32(66'(pr_reg[2]) + 66'(pr_reg[3]));
            w_reg.c <= sat32(66'(pr_reg[4]) + 66'(pr_reg[5]));
            w_reg.d <= sat32(66'(pr_reg[6]) + 66'(pr_reg[7]));
        end
        w_reg.tx <= sat32(66'(pr_reg[8]) + 66'(pr_reg[9]) + 66'(ptx2_reg));
        w_reg.ty <= sat32(66'(pr_reg[10]) + 66'(pr_reg[11]) + 66'(pty2_reg));
    end

    assign out_valid = v3_reg;
    assign world     = w_reg;

endmodule

// ===== design/atc_checker.sv =====
`timescale 1ns / 1ps
module atc_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic signed [31:0] world_a
);
    logic acc;
    assign acc = start && !busy;

    // Every accepted start yields a done, and every done stems from an accepted start.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        acc |-> ##3 done) else $error("missing done");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(acc, 3)) else $error("spurious done");
    // Nothing comes out in the cycle that follows reset.
    a_idle_after_reset: assert property (@(posedge clk)
        !rst_n |=> !done) else $error("done after reset");
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(world_a)) else $error("unknown word");
endmodule

bind affine_2d_transform_compose atc_checker u_atc_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .world_a (world_a)
);
